// ===== rtl/core/fseg_pkg.sv =====
// ----------------------------------------------------------------------------
// fseg_pkg
// shared types and constants of the frame segmenter
// ----------------------------------------------------------------------------
`default_nettype none

package fseg_pkg;

    // defaults for top level parameters
    localparam int PAYLOAD_BYTES_DEF = 1191;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // packet kinds
    localparam logic [1:0] KIND_START    = 2'd0;
    localparam logic [1:0] KIND_CONTINUE = 2'd1;
    localparam logic [1:0] KIND_END      = 2'd2;

    // header lengths in bytes
    localparam logic [3:0] HDR_NONE  = 4'd0;
    localparam logic [3:0] HDR_SHORT = 4'd4;
    localparam logic [3:0] HDR_LONG  = 4'd8;

    typedef struct packed {
        logic [7:0]  stream_id;
        logic [31:0] frame_number;
        logic [23:0] frame_length;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  flow_id;
        logic [1:0]  packet_kind;
        logic [7:0]  out_byte;
        logic        packet_end;
        logic [11:0] pad_bytes;
        logic        item_done;
    } result_t;

    // one classified input byte, handed from front to back
    typedef struct packed {
        logic [7:0]  stream;
        logic [1:0]  kind;
        logic [31:0] number;
        logic [23:0] length;
        logic [7:0]  data;
        logic [3:0]  hdr_len;
        logic        last;
        logic [11:0] pad;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/fseg_front.sv =====
// ----------------------------------------------------------------------------
// fseg_front
// accepts frame bytes, tracks packet boundaries and classifies each byte
// ----------------------------------------------------------------------------
`default_nettype none

module fseg_front
    import fseg_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire item_t item,
    input  wire logic  q_full,
    output logic       q_push,
    output cmd_t       q_data
);

    localparam logic [23:0] START_MAX = 24'(PAYLOAD_BYTES - 8);
    localparam logic [23:0] CONT_MAX  = 24'(PAYLOAD_BYTES - 4);
    localparam logic [12:0] PAYLOAD   = 13'(PAYLOAD_BYTES);

    logic        in_frame_reg;
    logic [23:0] pos_reg;
    logic [11:0] fill_reg;
    logic [11:0] left_reg;
    logic [1:0]  kind_reg;
    logic [23:0] held_length_reg;
    logic [31:0] held_number_reg;
    logic [7:0]  held_stream_reg;

    logic [23:0] len;
    logic [23:0] pos;
    logic [11:0] fill;
    logic [11:0] left;
    logic [1:0]  kind;
    logic [23:0] remaining;
    logic        new_pkt;
    logic [11:0] fill_next;
    logic [11:0] left_next;
    logic [23:0] pos_next;
    logic        pkt_last;
    logic [3:0]  hdr;
    logic [12:0] used;
    logic [11:0] pad;
    logic        frame_done;
    logic        take;

    assign full = q_full;

    always_comb
    begin
        len  = in_frame_reg ? held_length_reg : item.frame_length;
        pos  = in_frame_reg ? pos_reg : '0;
        fill = in_frame_reg ? fill_reg : '0;
        left = in_frame_reg ? left_reg : '0;
        kind = kind_reg;
        remaining = len - pos;
        new_pkt = (left == '0);
        if (new_pkt)
        begin
            fill = '0;
            if (pos == '0)
            begin
                kind = KIND_START;
                left = (remaining < START_MAX) ? remaining[11:0] : START_MAX[11:0];
            end
            else if (remaining > CONT_MAX)
            begin
                kind = KIND_CONTINUE;
                left = CONT_MAX[11:0];
            end
            else
            begin
                kind = KIND_END;
                left = remaining[11:0];
            end
        end
        fill_next  = fill + 12'd1;
        left_next  = left - 12'd1;
        pos_next   = pos + 24'd1;
        pkt_last   = (left_next == '0);
        hdr        = (kind == KIND_START) ? HDR_LONG : HDR_SHORT;
        used       = 13'(hdr) + 13'(fill_next);
        pad        = '0;
        if (pkt_last && kind != KIND_CONTINUE && used < PAYLOAD)
        begin
            pad = 12'(PAYLOAD - used);
        end
        frame_done = (pos_next >= len);
    end

    // a first byte of zero frame length is dropped
    assign take   = push && !q_full && (in_frame_reg || item.frame_length != '0);
    assign q_push = take;

    always_comb
    begin
        q_data.stream  = in_frame_reg ? held_stream_reg : item.stream_id;
        q_data.number  = in_frame_reg ? held_number_reg : item.frame_number;
        q_data.length  = len;
        q_data.kind    = kind;
        q_data.data    = item.data_byte;
        q_data.hdr_len = new_pkt ? hdr : HDR_NONE;
        q_data.last    = pkt_last;
        q_data.pad     = pad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            fill_reg     <= '0;
            left_reg     <= '0;
            kind_reg     <= KIND_START;
        end
        else if (take)
        begin
            in_frame_reg <= !frame_done;
            pos_reg      <= pos_next;
            fill_reg     <= fill_next;
            left_reg     <= frame_done ? 12'd0 : left_next;
            kind_reg     <= kind;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !in_frame_reg)
        begin
            held_length_reg <= item.frame_length;
            held_number_reg <= item.frame_number;
            held_stream_reg <= item.stream_id;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fseg_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// fseg_cmd_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module fseg_cmd_fifo
    import fseg_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_data,
    output logic      full,
    input  wire logic rd_en,
    output cmd_t      rd_data,
    output logic      empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr;
    logic          do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fseg_back.sv =====
// ----------------------------------------------------------------------------
// fseg_back
// expands each command into header beats and its data beat
// ----------------------------------------------------------------------------
`default_nettype none

module fseg_back
    import fseg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_empty,
    input  wire cmd_t q_data,
    output logic      q_pop,
    output logic      empty,
    input  wire logic pop,
    output result_t   result
);

    logic       out_valid_reg;
    result_t    out_reg;
    logic [3:0] step_reg;

    logic       advance;
    logic       last_beat;
    result_t    beat;

    assign advance   = !q_empty && (!out_valid_reg || pop);
    assign last_beat = (step_reg == q_data.hdr_len);
    assign q_pop     = advance && last_beat;
    assign empty     = !out_valid_reg;
    assign result    = out_reg;

    always_comb
    begin
        beat.flow_id     = q_data.stream;
        beat.packet_kind = q_data.kind;
        beat.packet_end  = 1'b0;
        beat.pad_bytes   = '0;
        beat.item_done   = 1'b0;
        beat.out_byte    = '0;
        if (last_beat)
        begin
            beat.out_byte   = q_data.data;
            beat.packet_end = q_data.last;
            beat.pad_bytes  = q_data.pad;
            beat.item_done  = 1'b1;
        end
        else
        begin
            case (step_reg)
                4'd0:    beat.out_byte = q_data.number[31:24];
                4'd1:    beat.out_byte = q_data.number[23:16];
                4'd2:    beat.out_byte = q_data.number[15:8];
                4'd3:    beat.out_byte = q_data.number[7:0];
                4'd4:    beat.out_byte = 8'd0;
                4'd5:    beat.out_byte = q_data.length[23:16];
                4'd6:    beat.out_byte = q_data.length[15:8];
                4'd7:    beat.out_byte = q_data.length[7:0];
                default: beat.out_byte = 8'd0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            step_reg      <= last_beat ? 4'd0 : step_reg + 4'd1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= beat;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/frame_segmenter_top.sv =====
// ----------------------------------------------------------------------------
// frame_segmenter_top
// cuts frames into fixed-size start / continue / end datagrams, byte by byte
// ----------------------------------------------------------------------------
//
//  channel   handshake       payload    beat
//  input     push / full     item_t     one frame byte with its frame fields
//  result    pop / empty     result_t   one packet byte (header or data)
//
//  one frame byte leaves as 1 result beat, or 5 / 9 beats when it opens a
//  packet (4-byte frame number, plus 4-byte length on a start packet)
//  input side takes a byte every cycle while the command queue has room;
//  result side gives one beat per cycle while beats are popped, so header
//  insertion is what fills the queue and holds full high
//  a byte's first beat is registered in the queue, then in the output register
//  reset clears the frame tracker, the queue and the output register
//  a held result stalls the back; the front runs on until the queue fills
//
`default_nettype none

module frame_segmenter_top
    import fseg_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire item_t item,
    output logic       empty,
    input  wire logic  pop,
    output result_t    result
);

    // front to queue
    logic q_wr;
    cmd_t q_wr_data;
    logic q_full;

    // queue to back
    logic q_rd;
    cmd_t q_rd_data;
    logic q_empty;

    // front: frame tracking and packet classification, one byte per cycle while the queue has room
    fseg_front #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_full (q_full),
        .q_push (q_wr),
        .q_data (q_wr_data)
    );

    // decouples the byte rate in from the beat rate out
    fseg_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // back: header beats then the data beat, into the output register
    fseg_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rd_data),
        .q_pop   (q_rd),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire

// ===== rtl/core/fseg_checker.sv =====
// ----------------------------------------------------------------------------
// fseg_checker
// port-level checks of the frame segmenter
// ----------------------------------------------------------------------------
`default_nettype none

module fseg_checker
    import fseg_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    push,
    input wire logic    full,
    input wire item_t   item,
    input wire logic    empty,
    input wire logic    pop,
    input wire result_t result
);

    // a waiting result beat holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("result beat changed while stalled");

    // header beats never mark a packet end or carry pad
    a_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !result.item_done |-> !result.packet_end && result.pad_bytes == 12'd0)
        else $error("header beat with end or pad");

    // continue packets are never padded
    a_cont: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.packet_kind == KIND_CONTINUE |-> result.pad_bytes == 12'd0)
        else $error("pad on continue packet");

    // beats of one byte follow without a gap and from the same stream
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !result.item_done
        |=> !empty && $stable(result.flow_id) && $stable(result.packet_kind))
        else $error("gap or stream change inside a byte's beats");

endmodule

bind frame_segmenter_top fseg_checker u_chk (.*);

`default_nettype wire

// ===== verif/frame_segmenter_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_segmenter_top_tb
// self-checking bench for the start / continue / end frame segmenter
//
// frames go in one byte per beat. A behavioral segmenter in the bench
// predicts every header and data beat, and each popped beat is compared
// field by field with the oldest prediction. A short table of hand-picked
// bytes comes first. Random frames follow: mostly short ones, plus a few
// long ones that fill start, continue and end packets. Both sides stall
// at random, with one stretch where neither side stalls.
// ----------------------------------------------------------------------------

module frame_segmenter_top_tb;

    import fseg_pkg::*;

    localparam int PAYLOAD        = PAYLOAD_BYTES_DEF;
    localparam int START_DATA_MAX = PAYLOAD - 8;   // data room of a start packet
    localparam int CONT_DATA_MAX  = PAYLOAD - 4;   // data room of later packets
    localparam int N_DIRECTED     = 12;
    localparam int RANDOM_ITEMS   = 350;
    localparam int DRAIN_CYCLES   = 20;             // idle wait for stray beats after the drain

    // one row of the directed table: the byte, and optionally its last beat typed in
    typedef struct packed {
        item_t   stim;
        logic    typed;
        result_t last_beat;
    } dir_row_t;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    push  = 1'b0;
    logic    pop   = 1'b0;
    item_t   item  = '0;
    logic    full;
    logic    empty;
    result_t result;

    // predicted beats, oldest first
    result_t expected_beats [$];
    int      errors      = 0;
    int      short_items = 0;
    bit      steady      = 1'b0;   // no stalls on either side while set

    // segmenter state mirrored by the bench
    logic [23:0] seg_pos;
    logic [11:0] seg_fill;
    logic [11:0] seg_left;
    logic [1:0]  seg_kind;
    logic [23:0] seg_length;
    logic [31:0] seg_number;
    logic [7:0]  seg_stream;
    logic        seg_busy;

    dir_row_t directed_rows [N_DIRECTED];

    always #2 clk = ~clk;

    frame_segmenter_top #(
        .PAYLOAD_BYTES (PAYLOAD)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    task automatic flag_error(input string msg);
        errors++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // queue one predicted beat of the current packet
    task automatic push_beat(input logic [7:0] b, input logic last, input logic [11:0] pad,
                             input logic done);
        result_t r;
        r.flow_id     = seg_stream;
        r.packet_kind = seg_kind;
        r.out_byte    = b;
        r.packet_end  = last;
        r.pad_bytes   = pad;
        r.item_done   = done;
        expected_beats.push_back(r);
    endtask

    // one accepted frame byte: header beats when it opens a packet, then its data beat
    task automatic segment_byte(input item_t it);
        int          remaining;
        int          chunk;
        int          used;
        int          i;
        logic [31:0] len_word;
        logic [11:0] pad;
        logic        last;
        // idle and zero length: byte dropped, nothing comes out
        if (!seg_busy && it.frame_length == '0)
            return;
        // first byte samples the frame fields, later bytes ignore them
        if (!seg_busy)
        begin
            seg_stream = it.stream_id;
            seg_number = it.frame_number;
            seg_length = it.frame_length;
            seg_pos    = '0;
            seg_left   = '0;
            seg_fill   = '0;
            seg_busy   = 1'b1;
        end
        if (seg_left == '0)
        begin
            remaining = int'(seg_length) - int'(seg_pos);
            if (seg_pos == '0)
            begin
                seg_kind = KIND_START;
                chunk    = (remaining < START_DATA_MAX) ? remaining : START_DATA_MAX;
            end
            else if (remaining > CONT_DATA_MAX)
            begin
                seg_kind = KIND_CONTINUE;
                chunk    = CONT_DATA_MAX;
            end
            else
            begin
                seg_kind = KIND_END;
                chunk    = remaining;
            end
            seg_left = 12'(chunk);
            seg_fill = '0;
            // frame number big-endian, then length (top byte always zero) on start
            for (i = 3; i >= 0; i--)
                push_beat(seg_number[8*i +: 8], 1'b0, '0, 1'b0);
            if (seg_kind == KIND_START)
            begin
                len_word = {8'd0, seg_length};
                for (i = 3; i >= 0; i--)
                    push_beat(len_word[8*i +: 8], 1'b0, '0, 1'b0);
            end
        end
        seg_fill = seg_fill + 12'd1;
        seg_left = seg_left - 12'd1;
        seg_pos  = seg_pos + 24'd1;
        last     = (seg_left == '0);
        pad      = '0;
        if (last && seg_kind != KIND_CONTINUE)
        begin
            used = int'((seg_kind == KIND_START) ? HDR_LONG : HDR_SHORT) + int'(seg_fill);
            pad  = (used < PAYLOAD) ? 12'(PAYLOAD - used) : '0;
        end
        push_beat(it.data_byte, last, pad, 1'b1);
        if (seg_pos >= seg_length)
        begin
            seg_busy = 1'b0;
            seg_left = '0;
        end
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    task automatic check_beat(input result_t got);
        result_t want;
        if (expected_beats.size() == 0)
        begin
            flag_error($sformatf("beat %h with nothing predicted", got));
            return;
        end
        want = expected_beats.pop_front();
        if (got.flow_id !== want.flow_id)
            flag_error($sformatf("flow_id %h, want %h", got.flow_id, want.flow_id));
        if (got.packet_kind !== want.packet_kind)
            flag_error($sformatf("packet_kind %h, want %h", got.packet_kind, want.packet_kind));
        if (got.out_byte !== want.out_byte)
            flag_error($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
        if (got.packet_end !== want.packet_end)
            flag_error($sformatf("packet_end %b, want %b", got.packet_end, want.packet_end));
        if (got.pad_bytes !== want.pad_bytes)
            flag_error($sformatf("pad_bytes %0d, want %0d", got.pad_bytes, want.pad_bytes));
        if (got.item_done !== want.item_done)
            flag_error($sformatf("item_done %b, want %b", got.item_done, want.item_done));
    endtask

    // about 22 stalls in a hundred calls, none during the steady stretch
    function automatic bit take_break();
        return !steady && ($urandom_range(0, 99) < 22);
    endfunction

    // pop side: values seen at the edge are the ones before it, so sampling is race free
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                check_beat(result);
            pop <= !take_break();
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // offer one byte and return at the edge that takes it, push left high
    task automatic send_item(input item_t it);
        while (take_break())
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        segment_byte(it);
    endtask

    // sender holds off until every predicted beat has been popped
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
    endtask

    // first byte carries the real length, later bytes carry random junk fields
    task automatic send_frame(input logic [23:0] len, input int unsigned n_bytes,
                              input bit counted);
        item_t       it;
        int unsigned k;
        for (k = 0; k < n_bytes; k++)
        begin
            it.stream_id    = 8'($urandom);
            it.frame_number = $urandom;
            it.frame_length = (k == 0) ? len : 24'($urandom);
            it.data_byte    = 8'($urandom);
            send_item(it);
            if (counted)
                short_items++;
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    initial
    begin
        item_t       junk;
        int          r;
        int          frame_idx;
        int unsigned len;
        directed_rows = '{
            // zero length while idle, all other fields at max: dropped
            '{'{8'hFF, 32'hFFFF_FFFF, 24'd0, 8'hFF}, 1'b0, '0},
            // one-byte frames at both extremes of every field
            '{'{8'hFF, 32'hFFFF_FFFF, 24'd1, 8'hFF}, 1'b1,
              '{8'hFF, KIND_START, 8'hFF, 1'b1, 12'd1182, 1'b1}},
            '{'{8'h00, 32'h0000_0000, 24'd1, 8'h00}, 1'b1,
              '{8'h00, KIND_START, 8'h00, 1'b1, 12'd1182, 1'b1}},
            // three-byte frame, later bytes carry fields that must be ignored
            '{'{8'h5A, 32'h1234_5678, 24'd3, 8'h11}, 1'b0, '0},
            '{'{8'hA5, 32'h0000_0000, 24'd0, 8'h22}, 1'b0, '0},
            '{'{8'hFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'h33}, 1'b1,
              '{8'h5A, KIND_START, 8'h33, 1'b1, 12'd1180, 1'b1}},
            // idle drop with everything zero
            '{'{8'h00, 32'h0000_0000, 24'd0, 8'h00}, 1'b0, '0},
            // two-byte frame, top bits of every field set
            '{'{8'h80, 32'h8000_0001, 24'd2, 8'h80}, 1'b0, '0},
            '{'{8'h01, 32'h7FFF_FFFF, 24'h80_0000, 8'h7F}, 1'b1,
              '{8'h80, KIND_START, 8'h7F, 1'b1, 12'd1181, 1'b1}},
            '{'{8'h01, 32'h0000_0100, 24'd1, 8'h55}, 1'b1,
              '{8'h01, KIND_START, 8'h55, 1'b1, 12'd1182, 1'b1}},
            // alternating bit patterns in the header bytes
            '{'{8'hAA, 32'hAAAA_5555, 24'd1, 8'hAA}, 1'b0, '0},
            '{'{8'h55, 32'h5555_AAAA, 24'd1, 8'h55}, 1'b0, '0}
        };
        seg_busy = 1'b0;
        seg_pos  = '0;
        seg_fill = '0;
        seg_left = '0;
        seg_kind = KIND_START;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, typed-in last beat overrides the prediction
        for (r = 0; r < N_DIRECTED; r++)
        begin
            send_item(directed_rows[r].stim);
            if (directed_rows[r].typed)
                expected_beats[expected_beats.size() - 1] = directed_rows[r].last_beat;
        end
        drain();

        // random frames, mostly short; long ones at a few points after a hold-off
        frame_idx = 0;
        while (short_items < RANDOM_ITEMS)
        begin
            steady = (short_items >= 150 && short_items < 250);
            if (frame_idx == 10 || frame_idx == 30 || frame_idx == 50)
            begin
                drain();
                // full start + continue + 1-byte end, full start + full end, then random
                if (frame_idx == 10)
                    len = START_DATA_MAX + CONT_DATA_MAX + 1;
                else if (frame_idx == 30)
                    len = START_DATA_MAX + CONT_DATA_MAX;
                else
                    len = $urandom_range(START_DATA_MAX + 1, START_DATA_MAX + CONT_DATA_MAX);
                send_frame(24'(len), len, 1'b0);
            end
            // stray zero-length bytes between frames
            if ($urandom_range(0, 99) < 10)
            begin
                junk.stream_id    = 8'($urandom);
                junk.frame_number = $urandom;
                junk.frame_length = '0;
                junk.data_byte    = 8'($urandom);
                send_item(junk);
            end
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 16) : $urandom_range(17, 64);
            send_frame(24'(len), len, 1'b1);
            frame_idx++;
        end
        steady = 1'b0;

        // largest length: a few bytes of a frame that never finishes
        drain();
        send_frame(24'hFF_FFFF, 6, 1'b0);

        // wait out the last beats, then a few more cycles for strays
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_beats.size() != 0)
            flag_error($sformatf("%0d predicted beats never came", expected_beats.size()));
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // hang guard, well past the slowest legal run
    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
